>>> rtl/core/nfrt_pkg.sv
// ----------------------------------------------------------------------------
// Noise floor range tracker package
// Shared widths, window limits, action and register codes.
// ----------------------------------------------------------------------------
package nfrt_pkg;

    localparam int FLOOR_W    = 13;
    localparam int SPAN_W     = 12;
    localparam int ACCUM_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [FLOOR_W-1:0] FLOOR_LO    = -13'sd2560;
    localparam logic signed [FLOOR_W-1:0] FLOOR_HI    = -13'sd480;
    localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -13'sd1600;

    localparam logic [SPAN_W-1:0] SPAN_LO    = 12'd480;
    localparam logic [SPAN_W-1:0] SPAN_HI    = 12'd2560;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 12'd960;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_FIT    = 2'd1,
        ACT_STICKY = 2'd2,
        ACT_LOAD   = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THROTTLE   = 3'd0,
        REG_DEADBAND   = 3'd1,
        REG_JUMP       = 3'd2,
        REG_ALPHA_RISE = 3'd3,
        REG_ALPHA_FALL = 3'd4
    } t_reg_index;

    function automatic logic signed [FLOOR_W-1:0] clamp_floor(input logic signed [16:0] v);
        logic signed [FLOOR_W-1:0] res;
        if (v < 17'(FLOOR_LO)) begin
            res = FLOOR_LO;
        end else if (v > 17'(FLOOR_HI)) begin
            res = FLOOR_HI;
        end else begin
            res = FLOOR_W'(v);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/nfrt_in_if.sv
// ----------------------------------------------------------------------------
// Noise floor range tracker input channel
// Valid/ready channel that carries one measurement or action word.
// ----------------------------------------------------------------------------
interface nfrt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [9:0]         elapsed_ms;
    logic               floor_valid;
    logic signed [15:0] floor_level;
    logic               sticky_value;
    logic signed [15:0] load_min;
    logic signed [15:0] load_max;

    modport source (
        output valid, action, elapsed_ms, floor_valid, floor_level,
               sticky_value, load_min, load_max,
        input  ready
    );
    modport sink (
        input  valid, action, elapsed_ms, floor_valid, floor_level,
               sticky_value, load_min, load_max,
        output ready
    );
endinterface

>>> rtl/core/nfrt_out_if.sv
// ----------------------------------------------------------------------------
// Noise floor range tracker output channel
// Valid/ready channel that carries one window result word.
// ----------------------------------------------------------------------------
interface nfrt_out_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] window_min;
    logic signed [12:0] window_max;
    logic               changed;
    logic               persist;
    logic               sticky_state;

    modport source (
        output valid, window_min, window_max, changed, persist, sticky_state,
        input  ready
    );
    modport sink (
        input  valid, window_min, window_max, changed, persist, sticky_state,
        output ready
    );
endinterface

>>> rtl/core/noise_floor_range_tracker.sv
// An accepted word is held in the input register, then its result is written
// to the result register; the state update and the single 16x12 multiply
// of the glide step sit between them. Throughput: one word per cycle unless
// a result waits; then the state holds and only an empty input register fills.
// Reset: synchronous, active low; window -1600/960, sticky off, accumulator
// cleared and the tuning registers at their defaults.
// ----------------------------------------------------------------------------
// Noise floor range tracker
// Keeps a display window from noise floor measurements with throttled,
// asymmetric smoothing of the floor.
// ----------------------------------------------------------------------------
module noise_floor_range_tracker
    import nfrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nfrt_in_if.sink               i_in,
    nfrt_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [9:0]  r_throttle;
    logic [7:0]  r_deadband;
    logic [11:0] r_jump;
    logic [15:0] r_alpha_rise;
    logic [15:0] r_alpha_fall;

    logic                      r_in_vld;
    t_action                   r_in_action;
    logic [9:0]                r_in_elapsed;
    logic                      r_in_fvalid;
    logic signed [15:0]        r_in_level;
    logic                      r_in_sval;
    logic signed [15:0]        r_in_lmin;
    logic signed [15:0]        r_in_lmax;

    logic signed [FLOOR_W-1:0] r_floor, n_floor;
    logic [SPAN_W-1:0]         r_span, n_span;
    logic                      r_sticky, n_sticky;
    logic                      r_started, n_started;
    logic [ACCUM_W-1:0]        r_accum, n_accum;
    logic                      n_persist;

    logic                      r_out_vld;
    logic signed [FLOOR_W-1:0] r_out_min;
    logic signed [FLOOR_W-1:0] r_out_max;
    logic                      r_out_changed;
    logic                      r_out_persist;
    logic                      r_out_sticky;

    logic                      advance;
    logic signed [16:0]        level_x;
    logic signed [16:0]        floor_x;
    logic signed [16:0]        diff;
    logic [16:0]               mag;
    logic [15:0]               alpha;
    logic [27:0]               prod;
    logic [28:0]               prod_rnd;
    logic [11:0]               step;
    logic signed [16:0]        glide_x;
    logic [ACCUM_W-1:0]        accum_sum;
    logic signed [16:0]        load_span;
    logic [13:0]               top_sum;

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throttle   <= 10'd100;
            r_deadband   <= 8'd2;
            r_jump       <= 12'd400;
            r_alpha_rise <= 16'd10060;
            r_alpha_fall <= 16'd2148;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THROTTLE:   r_throttle   <= i_cfg_data[9:0];
                REG_DEADBAND:   r_deadband   <= i_cfg_data[7:0];
                REG_JUMP:       r_jump       <= i_cfg_data[11:0];
                REG_ALPHA_RISE: r_alpha_rise <= i_cfg_data;
                REG_ALPHA_FALL: r_alpha_fall <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_action  <= t_action'(i_in.action);
            r_in_elapsed <= i_in.elapsed_ms;
            r_in_fvalid  <= i_in.floor_valid;
            r_in_level   <= i_in.floor_level;
            r_in_sval    <= i_in.sticky_value;
            r_in_lmin    <= i_in.load_min;
            r_in_lmax    <= i_in.load_max;
        end
    end

    always_comb begin
        level_x   = 17'(r_in_level);
        floor_x   = 17'(r_floor);
        diff      = level_x - floor_x;
        mag       = diff[16] ? 17'(-diff) : 17'(diff);
        alpha     = (diff > 17'sd0) ? r_alpha_rise : r_alpha_fall;
        prod      = alpha * mag[11:0];
        prod_rnd  = {1'b0, prod} + 29'd32768;
        step      = prod_rnd[27:16];
        glide_x   = diff[16] ? (floor_x - 17'($signed({1'b0, step})))
                             : (floor_x + 17'($signed({1'b0, step})));
        accum_sum = r_accum + ACCUM_W'(r_in_elapsed);
        load_span = 17'(r_in_lmax) - 17'(r_in_lmin);

        n_floor   = r_floor;
        n_span    = r_span;
        n_sticky  = r_sticky;
        n_started = r_started;
        n_accum   = r_accum;
        n_persist = 1'b0;

        case (r_in_action)
            ACT_TICK: begin
                if (r_sticky) begin
                    n_accum = accum_sum;
                    if (accum_sum >= ACCUM_W'(r_throttle)) begin
                        n_accum = '0;
                        if (r_in_fvalid) begin
                            if (!r_started) begin
                                n_floor   = clamp_floor(level_x);
                                n_started = 1'b1;
                            end else if (mag[15:0] < 16'(r_deadband)) begin
                                n_floor = r_floor;
                            end else if (mag[15:0] > 16'(r_jump)) begin
                                n_floor = clamp_floor(level_x);
                            end else begin
                                n_floor = clamp_floor(glide_x);
                            end
                        end
                    end
                end
            end
            ACT_FIT: begin
                if (r_in_fvalid) begin
                    n_floor   = clamp_floor(level_x);
                    n_persist = 1'b1;
                end
            end
            ACT_STICKY: begin
                n_sticky  = r_in_sval;
                n_started = 1'b0;
                n_persist = !r_in_sval;
            end
            ACT_LOAD: begin
                n_floor = clamp_floor(17'(r_in_lmin));
                if (load_span < $signed({5'd0, SPAN_LO})) begin
                    n_span = SPAN_LO;
                end else if (load_span > $signed({5'd0, SPAN_HI})) begin
                    n_span = SPAN_HI;
                end else begin
                    n_span = load_span[SPAN_W-1:0];
                end
                n_sticky  = r_in_sval;
                n_started = 1'b0;
            end
            default: ;
        endcase

        top_sum = 14'(n_floor) + {2'b00, n_span};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= FLOOR_RESET;
            r_span    <= SPAN_RESET;
            r_sticky  <= 1'b0;
            r_started <= 1'b0;
            r_accum   <= '0;
        end else if (advance) begin
            r_floor   <= n_floor;
            r_span    <= n_span;
            r_sticky  <= n_sticky;
            r_started <= n_started;
            r_accum   <= n_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_min     <= n_floor;
            r_out_max     <= top_sum[FLOOR_W-1:0];
            r_out_changed <= (n_floor != r_floor) || (n_span != r_span);
            r_out_persist <= n_persist;
            r_out_sticky  <= n_sticky;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.window_min   = r_out_min;
    assign o_out.window_max   = r_out_max;
    assign o_out.changed      = r_out_changed;
    assign o_out.persist      = r_out_persist;
    assign o_out.sticky_state = r_out_sticky;

endmodule

>>> rtl/core/nfrt_checker.sv
// ----------------------------------------------------------------------------
// Noise floor range tracker checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nfrt_checker
    import nfrt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [FLOOR_W-1:0] i_window_min,
    input  logic signed [FLOOR_W-1:0] i_window_max
);

    logic signed [FLOOR_W:0] width_x;

    assign width_x = (FLOOR_W+1)'(i_window_max) - (FLOOR_W+1)'(i_window_min);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_window_min >= FLOOR_LO) && (i_window_min <= FLOOR_HI))
        else $error("window floor out of range");

    a_span_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (width_x >= $signed({2'b00, SPAN_LO}))
                     && (width_x <= $signed({2'b00, SPAN_HI})))
        else $error("window span out of range");

endmodule

bind noise_floor_range_tracker nfrt_checker u_nfrt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_window_min (o_out.window_min),
    .i_window_max (o_out.window_max)
);

>>> tb/noise_floor_range_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Noise floor range tracker testbench
// Drives action words into the tracker and keeps a cycle-free model of the
// window, the sticky tracking state and the throttle accumulator. Every
// result word is checked field by field against that model. The run covers
// directed corners, register sweeps and random traffic with idling on both
// channels.
// ----------------------------------------------------------------------------
module noise_floor_range_tracker_tb;
    import nfrt_pkg::*;

    localparam int LATENCY        = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        t_action            action;
        logic [9:0]         elapsed_ms;
        logic               floor_valid;
        logic signed [15:0] floor_level;
        logic               sticky_value;
        logic signed [15:0] load_min;
        logic signed [15:0] load_max;
    } t_meas_word;

    typedef struct packed {
        logic signed [12:0] window_min;
        logic signed [12:0] window_max;
        logic               changed;
        logic               persist;
        logic               sticky_state;
    } t_window_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nfrt_in_if  in_if ();
    nfrt_out_if out_if ();

    noise_floor_range_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Model of the tracker state and its tuning registers.
    int          floor_now;
    int          span_now;
    bit          sticky_now;
    bit          tracking_live;
    logic [10:0] accum_ms;
    logic [9:0]  cfg_throttle_ms;
    logic [7:0]  cfg_deadband;
    logic [11:0] cfg_jump;
    logic [15:0] cfg_alpha_rise;
    logic [15:0] cfg_alpha_fall;

    t_window_word expected_windows[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int quiet_cycles;
    int mismatches;
    int words_sent;
    int windows_checked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int fit_floor(input int v);
        return (v < int'(FLOOR_LO)) ? int'(FLOOR_LO) : (v > int'(FLOOR_HI)) ? int'(FLOOR_HI) : v;
    endfunction

    function automatic int fit_span(input int v);
        return (v < int'(SPAN_LO)) ? int'(SPAN_LO) : (v > int'(SPAN_HI)) ? int'(SPAN_HI) : v;
    endfunction

    function automatic t_window_word predict_window(input t_meas_word w);
        t_window_word r;
        int          old_floor;
        int          old_span;
        int          level;
        int          diff;
        int          mag;
        int          step;
        longint      prod;
        logic [10:0] acc_sum;
        old_floor = floor_now;
        old_span  = span_now;
        level     = int'(w.floor_level);
        r.persist = 1'b0;
        case (w.action)
            ACT_TICK: begin
                if (sticky_now) begin
                    acc_sum = accum_ms + 11'(w.elapsed_ms);
                    if (acc_sum >= {1'b0, cfg_throttle_ms}) begin
                        accum_ms = '0;
                        if (w.floor_valid && !tracking_live) begin
                            floor_now     = fit_floor(level);
                            tracking_live = 1'b1;
                        end else if (w.floor_valid) begin
                            diff = level - floor_now;
                            mag  = (diff < 0) ? -diff : diff;
                            if (mag >= int'(cfg_deadband)) begin
                                if (mag > int'(cfg_jump)) begin
                                    floor_now = fit_floor(level);
                                end else begin
                                    prod = longint'(diff > 0 ? cfg_alpha_rise : cfg_alpha_fall)
                                           * longint'(mag);
                                    step = int'((prod + 64'sd32768) >>> 16);
                                    floor_now = fit_floor(diff < 0 ? floor_now - step
                                                                   : floor_now + step);
                                end
                            end
                        end
                    end else begin
                        accum_ms = acc_sum;
                    end
                end
            end
            ACT_FIT: begin
                if (w.floor_valid) begin
                    floor_now = fit_floor(level);
                    r.persist = 1'b1;
                end
            end
            ACT_STICKY: begin
                sticky_now    = w.sticky_value;
                tracking_live = 1'b0;
                r.persist     = !w.sticky_value;
            end
            default: begin
                floor_now     = fit_floor(int'(w.load_min));
                span_now      = fit_span(int'(w.load_max) - int'(w.load_min));
                sticky_now    = w.sticky_value;
                tracking_live = 1'b0;
            end
        endcase
        r.window_min   = 13'(floor_now);
        r.window_max   = 13'(floor_now + span_now);
        r.changed      = (floor_now != old_floor) || (span_now != old_span);
        r.sticky_state = sticky_now;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [12:0] want,
                                        input logic signed [12:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Handshake monitor: predicts on every accepted input word and checks
    // every accepted result word.
    always @(posedge i_clk) begin
        t_meas_word   taken;
        t_window_word want;
        t_window_word got;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                taken.action       = t_action'(in_if.action);
                taken.elapsed_ms   = in_if.elapsed_ms;
                taken.floor_valid  = in_if.floor_valid;
                taken.floor_level  = in_if.floor_level;
                taken.sticky_value = in_if.sticky_value;
                taken.load_min     = in_if.load_min;
                taken.load_max     = in_if.load_max;
                expected_windows.push_back(predict_window(taken));
                words_sent++;
            end
            if (out_if.valid && out_if.ready) begin
                got.window_min   = out_if.window_min;
                got.window_max   = out_if.window_max;
                got.changed      = out_if.changed;
                got.persist      = out_if.persist;
                got.sticky_state = out_if.sticky_state;
                if (expected_windows.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual min %0d max %0d",
                             $time, got.window_min, got.window_max);
                    mismatches++;
                end else begin
                    want = expected_windows.pop_front();
                    check_field("window_min", want.window_min, got.window_min);
                    check_field("window_max", want.window_max, got.window_max);
                    check_field("changed", want.changed, got.changed);
                    check_field("persist", want.persist, got.persist);
                    check_field("sticky_state", want.sticky_state, got.sticky_state);
                end
                windows_checked++;
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic t_meas_word meas_word(input t_action action, input int elapsed,
                                             input bit valid, input int level, input bit sval,
                                             input int lmin, input int lmax);
        t_meas_word w;
        w.action       = action;
        w.elapsed_ms   = 10'(elapsed);
        w.floor_valid  = valid;
        w.floor_level  = 16'(level);
        w.sticky_value = sval;
        w.load_min     = 16'(lmin);
        w.load_max     = 16'(lmax);
        return w;
    endfunction

    // Mostly well-formed tracking traffic: ticks in sticky mode with levels
    // around the current floor, mixed with fits, mode changes and loads.
    function automatic t_meas_word random_word();
        t_meas_word w;
        int         pick;
        int         reach;
        pick = $urandom_range(99);
        if (!sticky_now && pick < 40) begin
            w.action = ACT_STICKY;
        end else begin
            w.action = (pick < 70) ? ACT_TICK : (pick < 78) ? ACT_FIT :
                       (pick < 88) ? ACT_STICKY : ACT_LOAD;
        end
        pick = $urandom_range(99);
        w.elapsed_ms = (pick < 50) ? 10'($urandom_range(60)) :
                       (pick < 90) ? 10'($urandom_range(1023)) :
                       (pick < 95) ? 10'd0 : 10'h3FF;
        w.floor_valid  = ($urandom_range(99) < 85);
        w.sticky_value = ($urandom_range(99) < 75);
        pick = $urandom_range(99);
        if (pick < 60) begin
            reach = (pick < 20) ? 8 : (pick < 45) ? 80 : 700;
            w.floor_level = 16'(floor_now + int'($urandom_range(2 * reach)) - reach);
        end else if (pick < 80) begin
            w.floor_level = 16'(int'($urandom_range(2400)) - 2700);
        end else begin
            w.floor_level = 16'($urandom);
        end
        if ($urandom_range(1) == 0) begin
            w.load_min = 16'(int'($urandom_range(3000)) - 2900);
            w.load_max = 16'(int'(w.load_min) + int'($urandom_range(3000)) - 200);
        end else begin
            w.load_min = 16'($urandom);
            w.load_max = 16'($urandom);
        end
        return w;
    endfunction

    task automatic send_word(input t_meas_word w);
        int n_idle;
        n_idle = 0;
        while ($urandom_range(99) < send_idle_pct) n_idle++;
        @(negedge i_clk);
        if (n_idle > 0) begin
            in_if.valid <= 1'b0;
            repeat (n_idle) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.action       <= w.action;
        in_if.elapsed_ms   <= w.elapsed_ms;
        in_if.floor_valid  <= w.floor_valid;
        in_if.floor_level  <= w.floor_level;
        in_if.sticky_value <= w.sticky_value;
        in_if.load_min     <= w.load_min;
        in_if.load_max     <= w.load_max;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_THROTTLE:   cfg_throttle_ms = data[9:0];
            REG_DEADBAND:   cfg_deadband    = data[7:0];
            REG_JUMP:       cfg_jump        = data[11:0];
            REG_ALPHA_RISE: cfg_alpha_rise  = data;
            REG_ALPHA_FALL: cfg_alpha_fall  = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] throttle, input logic [15:0] deadband,
                                  input logic [15:0] jump, input logic [15:0] rise,
                                  input logic [15:0] fall);
        wait_drained();
        write_reg(REG_THROTTLE, throttle);
        write_reg(REG_DEADBAND, deadband);
        write_reg(REG_JUMP, jump);
        write_reg(REG_ALPHA_RISE, rise);
        write_reg(REG_ALPHA_FALL, fall);
    endtask

    task automatic test_fit_and_load();
        send_word(meas_word(ACT_TICK, 1023, 1'b1, 0, 1'b1, 0, 0));
        send_word(meas_word(ACT_FIT, 0, 1'b0, -1000, 1'b0, 0, 0));
        send_word(meas_word(ACT_FIT, 0, 1'b1, 32767, 1'b0, 0, 0));
        send_word(meas_word(ACT_FIT, 0, 1'b1, -32768, 1'b0, 0, 0));
        send_word(meas_word(ACT_FIT, 0, 1'b1, -1234, 1'b0, 0, 0));
        send_word(meas_word(ACT_LOAD, 0, 1'b0, 0, 1'b0, -32768, 32767));
        send_word(meas_word(ACT_LOAD, 0, 1'b0, 0, 1'b0, 32767, -32768));
        send_word(meas_word(ACT_LOAD, 0, 1'b0, 0, 1'b0, -1500, -500));
    endtask

    task automatic test_sticky_tracking();
        send_word(meas_word(ACT_STICKY, 0, 1'b0, 0, 1'b1, 0, 0));
        send_word(meas_word(ACT_STICKY, 0, 1'b0, 0, 1'b1, 0, 0));
        send_word(meas_word(ACT_TICK, 60, 1'b1, -900, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 40, 1'b0, -900, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 100, 1'b1, -900, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 100, 1'b1, -899, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 100, 1'b1, -898, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 100, 1'b1, -500, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 100, 1'b1, -1238, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 100, 1'b1, -1600, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 1023, 1'b1, 32767, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 100, 1'b1, -32768, 1'b0, 0, 0));
        send_word(meas_word(ACT_STICKY, 0, 1'b0, 0, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 500, 1'b1, -1000, 1'b0, 0, 0));
    endtask

    // Zero throttle period, rounding ties, ignored indexes and masked data.
    task automatic test_register_extremes();
        int idx;
        apply_settings(16'd0, 16'd0, 16'd4095, 16'd32768, 16'd32768);
        for (idx = int'(REG_ALPHA_FALL) + 1; idx < 2 ** CFG_IDX_W; idx++) begin
            write_reg(CFG_IDX_W'(idx), 16'hFFFF);
        end
        send_word(meas_word(ACT_STICKY, 0, 1'b0, 0, 1'b1, 0, 0));
        send_word(meas_word(ACT_TICK, 0, 1'b1, -1000, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 0, 1'b1, -999, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 0, 1'b1, -1002, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 0, 1'b1, -1001, 1'b0, 0, 0));
        apply_settings(16'hFFFF, 16'hFF03, 16'hF032, 16'd65535, 16'd1);
        send_word(meas_word(ACT_TICK, 1023, 1'b1, -1500, 1'b0, 0, 0));
        send_word(meas_word(ACT_TICK, 1023, 1'b1, -1490, 1'b0, 0, 0));
        send_word(meas_word(ACT_LOAD, 0, 1'b0, 0, 1'b1, -2000, -800));
    endtask

    task automatic test_backpressure();
        int n;
        apply_settings(16'd100, 16'd2, 16'd400, 16'd10060, 16'd2148);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        for (n = 0; n < 40; n++) send_word(random_word());
        wait_drained();
    endtask

    task automatic run_random_phase(input int n_words, input int idle_pct, input int stall_pct);
        int         done;
        t_meas_word w;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_words) begin
            w = random_word();
            if (w.action != ACT_TICK || sticky_now) done++;
            send_word(w);
        end
        wait_drained();
    endtask

    task automatic test_idle_patterns();
        apply_settings(16'd100, 16'd2, 16'd400, 16'd10060, 16'd2148);
        run_random_phase(340, 0, 0);
        apply_settings(16'd1, 16'd0, 16'd4095, 16'd65535, 16'd65535);
        run_random_phase(340, 48, 0);
        apply_settings(16'd1000, 16'd255, 16'd4095, 16'd32768, 16'd1);
        run_random_phase(340, 0, 48);
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random_phase(340, 28, 28);
        apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
        run_random_phase(340, 28, 28);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        in_if.valid        <= 1'b0;
        in_if.action       <= ACT_TICK;
        in_if.elapsed_ms   <= '0;
        in_if.floor_valid  <= 1'b0;
        in_if.floor_level  <= '0;
        in_if.sticky_value <= 1'b0;
        in_if.load_min     <= '0;
        in_if.load_max     <= '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_requests   = 0;
        mismatches      = 0;
        words_sent      = 0;
        windows_checked = 0;
        floor_now       = int'(FLOOR_RESET);
        span_now        = int'(SPAN_RESET);
        sticky_now      = 1'b0;
        tracking_live   = 1'b0;
        accum_ms        = '0;
        cfg_throttle_ms = 10'd100;
        cfg_deadband    = 8'd2;
        cfg_jump        = 12'd400;
        cfg_alpha_rise  = 16'd10060;
        cfg_alpha_fall  = 16'd2148;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fit_and_load();
        test_sticky_tracking();
        test_register_extremes();
        test_backpressure();
        test_idle_patterns();

        wait_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        mismatches += expected_windows.size();
        $display("Sent %0d action words and checked %0d window results.", words_sent,
                 windows_checked);
        $display("Covered fit, load, sticky tracking, register extremes, back-pressure and idling.");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
